### rtl/core/c8wd_pkg.sv
package c8wd_pkg;

    // Payload widths
    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;

    // Configuration port
    localparam int ADDR_W = 2;
    localparam int DATA_W = 32;
    localparam int WPR_W  = 6;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] REG_WORDS_PER_READ = 2'd0;

    // Word count limits and reset value
    localparam logic [WPR_W-1:0] MAX_WORDS = 6'd32;
    localparam logic [WPR_W-1:0] WPR_RESET = 6'd1;

    // CRC-8: polynomial x^8 + x^5 + x^4 + 1, MSB first, no final xor
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;

    // Fold one byte into a running CRC
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data_in);
        logic [BYTE_W-1:0] crc;
        crc = crc_in ^ data_in;
        for (int i = 0; i < BYTE_W; i++) begin
            if ((crc & CRC_TOP) != '0) begin
                crc = (crc << 1) ^ CRC_POLY;
            end else begin
                crc = crc << 1;
            end
        end
        return crc;
    endfunction

endpackage

### rtl/core/c8wd_byte_if.sv
// Received byte channel
interface c8wd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [c8wd_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/core/c8wd_word_if.sv
// Checked word channel
interface c8wd_word_if;
    logic                          valid;
    logic                          ready;
    logic [c8wd_pkg::WORD_W-1:0]   data_word;
    logic                          status;
    logic                          last;

    modport source (output valid, output data_word, output status, output last, input ready);
    modport sink   (input valid, input data_word, input status, input last, output ready);
endinterface

### rtl/core/c8wd_regs.sv
// Configuration register file behind an APB-style port
module c8wd_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [c8wd_pkg::ADDR_W-1:0]   paddr,
    input  logic [c8wd_pkg::DATA_W-1:0]   pwdata,
    output logic [c8wd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [c8wd_pkg::WPR_W-1:0]    o_words_per_read
);

    logic [c8wd_pkg::WPR_W-1:0] r_words_per_read;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write the word count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_per_read <= c8wd_pkg::WPR_RESET;
        end else if (wr_en && (paddr == c8wd_pkg::REG_WORDS_PER_READ)) begin
            r_words_per_read <= pwdata[c8wd_pkg::WPR_W-1:0];
        end
    end

    // Decode read data
    always_comb begin
        prdata = '0;
        unique case (paddr)
            c8wd_pkg::REG_WORDS_PER_READ: begin
                prdata = {{(c8wd_pkg::DATA_W-c8wd_pkg::WPR_W){1'b0}}, r_words_per_read};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_words_per_read = r_words_per_read;

endmodule

### rtl/core/crc8_checked_word_deframer.sv
// Channel   Dir  Payload                       Handshake
// i_byte    in   rx_byte[7:0]                  valid/ready
// o_word    out  data_word[15:0] status last   valid/ready
// apb       in   words_per_read at 0x0         psel/penable/pwrite, pready always high
//
// One received byte per cycle is sustained unless the output stalls. Each byte
// waits in the input register; a CRC byte moving on loads the result register.
// The CRC runs one byte per cycle into a running register, so no path folds
// more than one byte. Synchronous active-low reset clears both stages and the
// framing state. A stalled output only holds the input stage when that stage
// holds a CRC byte that produces a word.
module crc8_checked_word_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    c8wd_byte_if.sink                     i_byte,
    c8wd_word_if.source                   o_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [c8wd_pkg::ADDR_W-1:0]   paddr,
    input  logic [c8wd_pkg::DATA_W-1:0]   pwdata,
    output logic [c8wd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_CRC  = 2'd2
    } t_phase;

    logic [c8wd_pkg::WPR_W-1:0]  words_per_read;
    logic [c8wd_pkg::WPR_W-1:0]  eff_words;
    logic [c8wd_pkg::WPR_W:0]    idx_plus;
    logic                        final_word;
    logic                        mismatch;
    logic                        produce;
    logic                        advance;

    logic                        r_in_valid;
    logic [c8wd_pkg::BYTE_W-1:0] r_in_byte;
    t_phase                      r_phase;
    logic [c8wd_pkg::BYTE_W-1:0] r_high;
    logic [c8wd_pkg::BYTE_W-1:0] r_low;
    logic [c8wd_pkg::BYTE_W-1:0] r_crc;
    logic [c8wd_pkg::WPR_W-1:0]  r_word_idx;
    logic                        r_discard;
    logic                        r_out_valid;
    logic [c8wd_pkg::WORD_W-1:0] r_out_word;
    logic                        r_out_status;
    logic                        r_out_last;

    c8wd_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_words_per_read (words_per_read)
    );

    // Clamp the word count to 1..MAX_WORDS
    always_comb begin
        eff_words = words_per_read;
        if (words_per_read == '0) begin
            eff_words = {{(c8wd_pkg::WPR_W-1){1'b0}}, 1'b1};
        end else if (words_per_read > c8wd_pkg::MAX_WORDS) begin
            eff_words = c8wd_pkg::MAX_WORDS;
        end
    end

    // Word position and CRC check for the byte in the input register
    assign idx_plus   = {1'b0, r_word_idx} + {{c8wd_pkg::WPR_W{1'b0}}, 1'b1};
    assign final_word = idx_plus >= {1'b0, eff_words};
    assign mismatch   = r_crc != r_in_byte;
    assign produce    = r_in_valid && (r_phase == PH_CRC) && !r_discard;
    assign advance    = r_in_valid && (!produce || !r_out_valid || o_word.ready);

    assign i_byte.ready = !r_in_valid || advance;

    // Input register: take a new byte whenever it is empty or the held one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in_byte  <= '0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
            r_in_byte  <= i_byte.rx_byte;
        end
    end

    // Framing state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HIGH;
            r_high       <= '0;
            r_low        <= '0;
            r_crc        <= c8wd_pkg::CRC_INIT;
            r_word_idx   <= '0;
            r_discard    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_word   <= '0;
            r_out_status <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one replaces it
            if (r_out_valid && o_word.ready && !(advance && produce)) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                unique case (r_phase)
                    PH_LOW: begin
                        r_low   <= r_in_byte;
                        r_crc   <= c8wd_pkg::crc8_byte(r_crc, r_in_byte);
                        r_phase <= PH_CRC;
                    end
                    PH_CRC: begin
                        r_phase    <= PH_HIGH;
                        r_word_idx <= final_word ? '0 : idx_plus[c8wd_pkg::WPR_W-1:0];
                        if (r_discard) begin
                            // swallow the rest of an aborted read
                            if (final_word) begin
                                r_discard <= 1'b0;
                            end
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_word   <= {r_high, r_low};
                            r_out_status <= mismatch;
                            r_out_last   <= final_word || mismatch;
                            r_discard    <= mismatch && !final_word;
                        end
                    end
                    default: begin
                        r_high  <= r_in_byte;
                        r_crc   <= c8wd_pkg::crc8_byte(c8wd_pkg::CRC_INIT, r_in_byte);
                        r_phase <= PH_LOW;
                    end
                endcase
            end
        end
    end

    assign o_word.valid     = r_out_valid;
    assign o_word.data_word = r_out_word;
    assign o_word.status    = r_out_status;
    assign o_word.last      = r_out_last;

endmodule

### rtl/core/c8wd_checker.sv
// Port-level checks on the deframer
module c8wd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [c8wd_pkg::WORD_W-1:0]   i_out_word,
    input logic                          i_out_status,
    input logic                          i_out_last
);

    // A stalled word holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_word) && $stable(i_out_status)
             && $stable(i_out_last)))
        else $error("stalled word changed");

    // An aborted read always ends its word stream
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status) |-> i_out_last)
        else $error("mismatch word not marked last");

    // A new word is first seen only after a byte was taken through the input register
    a_word_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("word without a received byte");

    // An empty output never blocks the byte channel
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("byte channel stalled with empty output");

endmodule

bind crc8_checked_word_deframer c8wd_checker u_c8wd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_byte.valid),
    .i_in_ready   (i_byte.ready),
    .i_out_valid  (o_word.valid),
    .i_out_ready  (o_word.ready),
    .i_out_word   (o_word.data_word),
    .i_out_status (o_word.status),
    .i_out_last   (o_word.last)
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic [c8wd_pkg::WORD_W-1:0] data_word;
        logic                        status;
        logic                        last;
    } t_word;

    logic i_clk;
    logic i_rst_n;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [c8wd_pkg::ADDR_W-1:0] paddr;
    logic [c8wd_pkg::DATA_W-1:0] pwdata;
    logic [c8wd_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    c8wd_byte_if byte_ch ();
    c8wd_word_if word_ch ();

    crc8_checked_word_deframer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_word  (word_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Deframer state as predicted from the accepted bytes
    logic [1:0]                  rx_phase;
    logic [c8wd_pkg::BYTE_W-1:0] hold_hi;
    logic [c8wd_pkg::BYTE_W-1:0] hold_lo;
    logic [c8wd_pkg::WPR_W-1:0]  words_done;
    logic                        swallowing;
    logic [c8wd_pkg::WPR_W-1:0]  words_cfg;

    t_word exp_words[$];
    int    fail_count = 0;
    bit    src_quiet  = 0;
    bit    snk_quiet  = 0;

    always #5 i_clk = ~i_clk;

    // Running CRC-8, one byte at a time, MSB first
    function automatic logic [c8wd_pkg::BYTE_W-1:0] crc8_fold(
            input logic [c8wd_pkg::BYTE_W-1:0] crc,
            input logic [c8wd_pkg::BYTE_W-1:0] b);
        logic [c8wd_pkg::BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < c8wd_pkg::BYTE_W; i++) begin
            c = c[c8wd_pkg::BYTE_W-1] ? ((c << 1) ^ c8wd_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Words in one read after clamping the register to 1..MAX_WORDS
    function automatic int read_len();
        int n;
        n = int'(words_cfg);
        if (n < 1) n = 1;
        if (n > int'(c8wd_pkg::MAX_WORDS)) n = int'(c8wd_pkg::MAX_WORDS);
        return n;
    endfunction

    // Advance the predicted state by one byte and queue any word it gives
    function automatic void deframe_byte(input logic [c8wd_pkg::BYTE_W-1:0] b);
        logic [c8wd_pkg::BYTE_W-1:0] crc;
        logic                        fin;
        logic                        bad;
        if (rx_phase == 2'd1) begin
            hold_lo  = b;
            rx_phase = 2'd2;
            return;
        end
        if (rx_phase != 2'd2) begin
            hold_hi  = b;
            rx_phase = 2'd1;
            return;
        end
        rx_phase   = 2'd0;
        fin        = (int'(words_done) + 1 >= read_len());
        words_done = fin ? '0 : words_done + 1'b1;
        if (swallowing) begin
            if (fin) swallowing = 1'b0;
            return;
        end
        crc = crc8_fold(crc8_fold(c8wd_pkg::CRC_INIT, hold_hi), hold_lo);
        bad = (crc != b);
        exp_words.push_back('{data_word: {hold_hi, hold_lo}, status: bad, last: fin | bad});
        if (bad && !fin) swallowing = 1'b1;
    endfunction

    // Send one byte after a random gap; valid stays high if the next follows at once
    task automatic send_byte(input logic [c8wd_pkg::BYTE_W-1:0] b);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        deframe_byte(b);
    endtask

    // Send a data word and its CRC, optionally with the CRC spoilt
    task automatic send_checked_word(input logic [c8wd_pkg::WORD_W-1:0] w, input bit spoil);
        logic [c8wd_pkg::BYTE_W-1:0] crc;
        crc = crc8_fold(crc8_fold(c8wd_pkg::CRC_INIT, w[15:8]), w[7:0]);
        if (spoil) crc ^= c8wd_pkg::BYTE_W'($urandom_range(1, 255));
        send_byte(w[15:8]);
        send_byte(w[7:0]);
        send_byte(crc);
    endtask

    // Drop valid and hold until every expected word is out and the pipe is empty
    task automatic wait_idle();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (exp_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write words_per_read over APB once idle, then read it back
    task automatic set_words_per_read(input logic [c8wd_pkg::DATA_W-1:0] v);
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= c8wd_pkg::REG_WORDS_PER_READ;
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        words_cfg = v[c8wd_pkg::WPR_W-1:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== c8wd_pkg::DATA_W'(words_cfg)) begin
            $error("prdata: expected %h, actual %h", c8wd_pkg::DATA_W'(words_cfg), prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reset count of one: a clean word at the byte extremes, then a bad CRC on the final word
    task automatic test_single_word_reads();
        send_checked_word(16'h0000, 1'b0);
        send_checked_word(16'hFFFF, 1'b1);
        wait_idle();
    endtask

    // Three-word read: clean word, mismatch, then the rest of the read is swallowed
    task automatic test_abort_and_swallow();
        set_words_per_read(32'd3);
        send_checked_word(16'h1234, 1'b0);
        send_checked_word(16'hBEEF, 1'b1);
        send_checked_word(16'h00FF, 1'b0);
        wait_idle();
    endtask

    // Oversized count clamps to the maximum; shrink it mid-read so the next word ends it
    task automatic test_count_change_mid_read();
        set_words_per_read(32'hFFFF_FFFF);
        send_checked_word(16'hFF00, 1'b0);
        send_checked_word(16'h8001, 1'b0);
        set_words_per_read(32'd0);
        send_checked_word(16'h7FFE, 1'b0);
        wait_idle();
    endtask

    // One burst: mostly well-formed reads, some noise and cut-short words
    task automatic send_burst(output int n);
        int pick;
        int words;
        logic [c8wd_pkg::WORD_W-1:0] w;
        n    = 0;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            repeat ($urandom_range(1, 4)) begin
                send_byte(c8wd_pkg::BYTE_W'($urandom));
                n++;
            end
        end else if (pick == 1) begin
            w = c8wd_pkg::WORD_W'($urandom);
            send_byte(w[15:8]);
            n++;
            if ($urandom_range(0, 1)) begin
                send_byte(w[7:0]);
                n++;
            end
        end else begin
            // realign to a group boundary, then finish the read
            while (rx_phase != 2'd0) begin
                send_byte(c8wd_pkg::BYTE_W'($urandom));
                n++;
            end
            words = read_len() - int'(words_done);
            // a shrunk count leaves the read already past its end: one word closes it
            if (words < 1) words = 1;
            if (words > 6) words = $urandom_range(1, 6);
            repeat (words) begin
                send_checked_word(c8wd_pkg::WORD_W'($urandom), $urandom_range(0, 7) == 0);
                n += 3;
            end
        end
    endtask

    // Random phases over the count extremes, clamped values and typical sizes
    task automatic test_random_reads();
        int sent;
        int budget;
        int n;
        logic [c8wd_pkg::DATA_W-1:0] v;
        sent = 0;
        while (sent < 450) begin
            case ($urandom_range(0, 5))
                0:       v = 1;
                1:       v = 32;
                2:       v = 0;
                3:       v = $urandom_range(33, 63);
                4:       v = $urandom_range(1, 32);
                default: v = $urandom_range(2, 4);
            endcase
            if ($urandom_range(0, 1)) begin
                v[c8wd_pkg::DATA_W-1:c8wd_pkg::WPR_W] =
                    (c8wd_pkg::DATA_W-c8wd_pkg::WPR_W)'($urandom);
            end
            set_words_per_read(v);
            src_quiet = ($urandom_range(0, 3) == 0);
            snk_quiet = ($urandom_range(0, 3) == 0);
            budget    = sent + $urandom_range(30, 70);
            while (sent < budget) begin
                send_burst(n);
                sent += n;
            end
        end
        src_quiet = 1'b0;
        snk_quiet = 1'b0;
    endtask

    // Output side: stall a random number of cycles before each word
    always begin : word_sink
        int stall;
        stall = snk_quiet ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (stall > 0) begin
            word_ch.ready <= 1'b0;
            repeat (stall) @(negedge i_clk);
        end
        word_ch.ready <= 1'b1;
        do @(posedge i_clk); while (!(word_ch.valid && word_ch.ready));
    end

    // Compare each word taken against the oldest prediction
    always @(posedge i_clk) begin : word_check
        t_word want;
        if (i_rst_n && word_ch.valid && word_ch.ready) begin
            if (exp_words.size() == 0) begin
                $error("unexpected word: data_word %h status %b last %b",
                       word_ch.data_word, word_ch.status, word_ch.last);
                fail_count++;
            end else begin
                want = exp_words.pop_front();
                if (word_ch.data_word !== want.data_word) begin
                    $error("data_word: expected %h, actual %h", want.data_word,
                           word_ch.data_word);
                    fail_count++;
                end
                if (word_ch.status !== want.status) begin
                    $error("status: expected %b, actual %b", want.status, word_ch.status);
                    fail_count++;
                end
                if (word_ch.last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, word_ch.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int guard;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        word_ch.ready   = 1'b0;
        rx_phase        = 2'd0;
        hold_hi         = '0;
        hold_lo         = '0;
        words_done      = '0;
        swallowing      = 1'b0;
        words_cfg       = c8wd_pkg::WPR_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_word_reads();
        test_abort_and_swallow();
        test_count_change_mid_read();
        test_random_reads();

        // Drain what is left, with a limit
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        guard = 0;
        while (exp_words.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (exp_words.size() != 0) begin
            $error("%0d expected words never arrived", exp_words.size());
            fail_count += exp_words.size();
        end
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[crc8_checked_word_deframer] OK");
        end else begin
            $display("[crc8_checked_word_deframer] ERROR");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #2_000_000;
        $display("[crc8_checked_word_deframer] ERROR");
        $finish;
    end

endmodule
